[hdl/bsdpa_pkg.sv]
// ----------------------------------------------------------------------------
// Block scaled dot product package
// Shared types, codes and decode functions for the dot product unit.
// ----------------------------------------------------------------------------
package bsdpa_pkg;

    localparam int EW = 13;
    typedef logic signed [EW-1:0] t_exp;
    typedef logic [2:0] t_kind;

    localparam t_kind K_ZERO = 3'd0;
    localparam t_kind K_NORM = 3'd1;
    localparam t_kind K_PINF = 3'd2;
    localparam t_kind K_NINF = 3'd3;
    localparam t_kind K_NAN  = 3'd4;

    localparam logic [2:0] FMT_FP16 = 3'd0;
    localparam logic [2:0] FMT_BF16 = 3'd1;
    localparam logic [2:0] FMT_E5M2 = 3'd2;
    localparam logic [2:0] FMT_E4M3 = 3'd3;
    localparam logic [2:0] FMT_E2M1 = 3'd4;

    localparam logic [2:0] REG_AB_FORMAT    = 3'd0;
    localparam logic [2:0] REG_ACC_FORMAT   = 3'd1;
    localparam logic [2:0] REG_MANT_WIDTH   = 3'd2;
    localparam logic [2:0] REG_SCALE_ENABLE = 3'd3;
    localparam logic [2:0] REG_GROUP_SIZE   = 3'd4;
    localparam logic [2:0] REG_SCALE_FORMAT = 3'd5;
    localparam logic [2:0] REG_ROUND_SELECT = 3'd6;

    localparam logic [31:0] NAN32  = 32'h7FFF_FFFF;
    localparam logic [31:0] PINF32 = 32'h7F80_0000;
    localparam logic [31:0] NINF32 = 32'hFF80_0000;
    localparam logic [15:0] NAN16  = 16'h7FFF;
    localparam logic [15:0] PINF16 = 16'h7C00;
    localparam logic [15:0] NINF16 = 16'hFC00;

    typedef struct packed {
        logic [63:0] a_elems;
        logic [63:0] b_elems;
        logic [31:0] scale_a;
        logic [31:0] scale_b;
        logic [2:0]  valid_count;
        logic        first;
        logic [31:0] init_acc;
    } t_in_item;

    typedef struct packed {
        logic [31:0] acc_bits;
    } t_out_item;

    typedef struct packed {
        logic [2:0] cfg_index;
        logic [5:0] cfg_data;
    } t_cfg_item;

    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [10:0] sig;
        t_exp        exp;
    } t_elem;

    typedef struct packed {
        logic       nan;
        logic       zero;
        logic [3:0] sig;
        t_exp       exp;
    } t_scl;

    typedef struct packed {
        t_kind       spec;
        logic        zero;
        logic        sign;
        t_exp        exp;
        logic [56:0] mag;
        logic        fp16;
        logic        rne;
    } t_rnd_in;

    function automatic t_elem decode_fmt(input logic [15:0] raw, input int ne,
                                         input int nm, input int bias, input int style);
        t_elem       e;
        logic [15:0] ex;
        logic [15:0] m;
        ex = (raw >> nm) & ((16'd1 << ne) - 16'd1);
        m  = raw & ((16'd1 << nm) - 16'd1);
        e  = '0;
        e.sign = raw[ne+nm];
        if (style == 0 && ex == ((16'd1 << ne) - 16'd1)) begin
            if (m != 16'd0) e.nan = 1'b1;
            else e.inf = 1'b1;
        end else if (style == 1 && raw[6:0] == 7'h7F) begin
            e.nan = 1'b1;
        end else if (ex == 16'd0 && m == 16'd0) begin
            e.zero = 1'b1;
        end else if (ex == 16'd0) begin
            e.sig = m[10:0];
            e.exp = t_exp'(1 - bias - nm);
        end else begin
            e.sig = m[10:0] | (11'd1 << nm);
            e.exp = t_exp'(int'(ex) - bias - nm);
        end
        return e;
    endfunction

    function automatic t_elem decode_elem(input logic [15:0] raw, input logic [2:0] fmt);
        t_elem z;
        z      = '0;
        z.zero = 1'b1;
        case (fmt)
            FMT_FP16: z = decode_fmt(raw, 5, 10, 15, 0);
            FMT_BF16: z = decode_fmt(raw, 8, 7, 127, 0);
            FMT_E5M2: z = decode_fmt({8'd0, raw[7:0]}, 5, 2, 15, 0);
            FMT_E4M3: z = decode_fmt({8'd0, raw[7:0]}, 4, 3, 7, 1);
            FMT_E2M1: z = decode_fmt({12'd0, raw[3:0]}, 2, 1, 1, 2);
            default: ;
        endcase
        return z;
    endfunction

    function automatic t_scl decode_scale(input logic [7:0] v, input logic fmt);
        t_scl s;
        s = '0;
        if (!fmt) begin
            if (v == 8'hFF) s.nan = 1'b1;
            else if (v == 8'h00) s.zero = 1'b1;
            else begin
                s.sig = 4'd1;
                s.exp = t_exp'(int'(v) - 127);
            end
        end else if (v == 8'h7F || v == 8'hFF) begin
            s.nan = 1'b1;
        end else if (v[6:0] == 7'd0) begin
            s.zero = 1'b1;
        end else if (v[6:3] == 4'd0) begin
            s.sig = {1'b0, v[2:0]};
            s.exp = t_exp'(-9);
        end else begin
            s.sig = {1'b1, v[2:0]};
            s.exp = t_exp'(int'(v[6:3]) - 10);
        end
        return s;
    endfunction

endpackage

[hdl/bsdpa_chan_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready channel
// One transfer moves a payload when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bsdpa_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

[hdl/bsdpa_round.sv]
// ----------------------------------------------------------------------------
// Result rounder
// Packs a normalized exact sum into fp32 or fp16 with nearest-even or truncation.
// ----------------------------------------------------------------------------
module bsdpa_round (
    input  bsdpa_pkg::t_rnd_in i_rnd,
    output logic [31:0]        o_bits
);
    import bsdpa_pkg::*;

    logic signed [13:0] be32, be32b, be16, be16b, nbe32, nbe16;
    logic [22:0] mant32;
    logic [23:0] mant32r, full32, sub32, sub32r;
    logic [9:0]  mant16;
    logic [10:0] mant16r, full16, sub16, sub16r;
    logic [4:0]  sh32;
    logic [3:0]  sh16;
    logic        up32, up16, sup32, sup16;
    logic [31:0] res32;
    logic [15:0] res16;
    logic        s;

    always_comb begin
        s      = i_rnd.sign;
        be32   = 14'(i_rnd.exp) + 14'sd127;
        be16   = 14'(i_rnd.exp) + 14'sd15;
        nbe32  = 14'sd1 - be32;
        nbe16  = 14'sd1 - be16;

        mant32  = i_rnd.mag[55:33];
        up32    = i_rnd.rne && i_rnd.mag[32] && ((|i_rnd.mag[31:0]) || mant32[0]);
        mant32r = {1'b0, mant32} + 24'(up32);
        be32b   = be32 + 14'(mant32r[23]);
        full32  = i_rnd.mag[56:33];
        sh32    = nbe32[4:0];
        sub32   = full32 >> sh32;
        sup32   = i_rnd.rne && full32[sh32 - 5'd1]
                  && ((|(full32 & ((24'd1 << (sh32 - 5'd1)) - 24'd1))) || sub32[0]);
        sub32r  = sub32 + 24'(sup32);
        if (be32 >= 14'sd255) begin
            res32 = {s, 8'hFF, 23'd0};
        end else if (be32 > 14'sd0) begin
            if (be32b >= 14'sd255) res32 = {s, 8'hFF, 23'd0};
            else res32 = {s, be32b[7:0], mant32r[22:0]};
        end else if (nbe32 > 14'sd24) begin
            res32 = {s, 31'd0};
        end else if (sub32r[23]) begin
            res32 = {s, 8'd1, 23'd0};
        end else begin
            res32 = {s, 8'd0, sub32r[22:0]};
        end

        mant16  = i_rnd.mag[55:46];
        up16    = i_rnd.rne && i_rnd.mag[45] && ((|i_rnd.mag[44:0]) || mant16[0]);
        mant16r = {1'b0, mant16} + 11'(up16);
        be16b   = be16 + 14'(mant16r[10]);
        full16  = i_rnd.mag[56:46];
        sh16    = nbe16[3:0];
        sub16   = full16 >> sh16;
        sup16   = i_rnd.rne && full16[sh16 - 4'd1]
                  && ((|(full16 & ((11'd1 << (sh16 - 4'd1)) - 11'd1))) || sub16[0]);
        sub16r  = sub16 + 11'(sup16);
        if (be16 >= 14'sd31) begin
            res16 = {s, 5'h1F, 10'd0};
        end else if (be16 > 14'sd0) begin
            if (be16b >= 14'sd31) res16 = {s, 5'h1F, 10'd0};
            else res16 = {s, be16b[4:0], mant16r[9:0]};
        end else if (nbe16 > 14'sd11) begin
            res16 = {s, 15'd0};
        end else if (sub16r[10]) begin
            res16 = {s, 5'd1, 10'd0};
        end else begin
            res16 = {s, 5'd0, sub16r[9:0]};
        end

        if (i_rnd.spec == K_NAN) o_bits = i_rnd.fp16 ? {16'd0, NAN16} : NAN32;
        else if (i_rnd.spec == K_PINF) o_bits = i_rnd.fp16 ? {16'd0, PINF16} : PINF32;
        else if (i_rnd.spec == K_NINF) o_bits = i_rnd.fp16 ? {16'd0, NINF16} : NINF32;
        else if (i_rnd.zero) o_bits = 32'd0;
        else o_bits = i_rnd.fp16 ? {16'd0, res16} : res32;
    end
endmodule

[hdl/block_scaled_dot_product_accumulate.sv]
// ----------------------------------------------------------------------------
// Block scaled dot product accumulate
// Sums lane products, optional group scales and the accumulator on one serial
// adder and one shared normalizer, then rounds to fp32 or fp16.
// Each item passes through the normalizer, which shifts each term into place
// step by step, and through two passes of the serial adder over each term list.
// Throughput: one item at a time; the next transfer is taken once the result
// is in the output register. Reset (synchronous, active low) clears control,
// restores the register defaults and zeroes the accumulator.
// ----------------------------------------------------------------------------
module block_scaled_dot_product_accumulate #(
    parameter int DP_WIDTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsdpa_chan_if.sink    i_in,
    bsdpa_chan_if.source  o_out,
    bsdpa_chan_if.sink    i_cfg
);
    import bsdpa_pkg::*;

    localparam int NE = 2 * DP_WIDTH + 1;
    localparam int IW = $clog2(NE);
    localparam int HW = $clog2(NE + 1);
    localparam int LW = (DP_WIDTH > 1) ? $clog2(DP_WIDTH) : 1;
    localparam int SW = 5;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CDEC   = 4'd1;
    localparam logic [3:0] S_PROD   = 4'd2;
    localparam logic [3:0] S_NORM   = 4'd3;
    localparam logic [3:0] S_MAX    = 4'd4;
    localparam logic [3:0] S_SUM    = 4'd5;
    localparam logic [3:0] S_REND   = 4'd6;
    localparam logic [3:0] S_GSC0   = 4'd7;
    localparam logic [3:0] S_GSCL   = 4'd8;
    localparam logic [3:0] S_GNEXT  = 4'd9;
    localparam logic [3:0] S_RND    = 4'd10;
    localparam logic [3:0] S_GSTART = 4'd11;
    localparam logic [3:0] S_FSTART = 4'd12;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_ab_fmt;
    logic        r_acc_fmt, r_sc_en, r_sc_fmt, r_rsel;
    logic [5:0]  r_mw;
    logic [2:0]  r_gsz;

    logic [16*DP_WIDTH-1:0] r_a, n_a, r_b, n_b;
    logic [8*DP_WIDTH-1:0]  r_sa, n_sa, r_sb, n_sb;
    logic [31:0] r_c, n_c;
    logic [LW-1:0] r_lane, n_lane, r_grp, n_grp;
    logic [IW-1:0] r_i, n_i, r_lo, n_lo, r_dst, n_dst;
    logic [HW-1:0] r_hi, n_hi;
    logic [SW-1:0] r_gstart, n_gstart;
    logic [3:0]  r_ret, n_ret;
    logic        r_nfinal, n_nfinal, r_grpmode, n_grpmode;
    logic [56:0] r_m, n_m;
    t_exp        r_e, n_e, r_mx, n_mx;
    logic        r_nsgn, n_nsgn;
    logic        r_any, n_any, r_fnan, n_fnan, r_fpi, n_fpi, r_fni, n_fni;
    logic signed [53:0] r_sum, n_sum;
    logic [7:0]  r_sprod, n_sprod;
    t_kind       r_fspec, n_fspec;
    logic        r_fzero, n_fzero;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_out, n_out, r_acc, n_acc;

    t_kind       r_kind [NE];
    logic        r_tsg  [NE];
    t_exp        r_texp [NE];
    logic [48:0] r_tsig [NE];

    logic        wr_en, clr_all;
    logic [IW-1:0] wr_idx, rd_idx;
    t_kind       wr_kind, rd_kind;
    logic        wr_sgn, rd_sgn;
    t_exp        wr_exp, rd_exp;
    logic [48:0] wr_sig, rd_sig;

    logic [5:0]  w_c;
    logic [48:0] keep;
    logic [2:0]  sg_c, valid_c;
    t_in_item    in_d;
    t_kind       c_kind;
    logic        c_sgn;
    logic [23:0] c_sig;
    t_exp        c_exp;
    t_elem       ea, eb;
    t_scl        sca, scb;
    t_kind       spec;
    t_exp        sh;
    logic [48:0] al;
    logic [56:0] sum_abs;
    logic [SW-1:0] g_end, g_next;
    logic [IW-1:0] p_dst;
    t_rnd_in     rnd_in;
    logic [31:0] rnd_bits;

    assign in_d          = i_in.payload;
    assign i_in.ready    = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_ovalid;
    assign o_out.payload.acc_bits = r_out;

    assign w_c  = (r_mw == 6'd0) ? 6'd1 : ((r_mw > 6'd48) ? 6'd48 : r_mw);
    assign keep = ~((49'd1 << (6'd48 - w_c)) - 49'd1);
    assign sg_c = (r_gsz == 3'd0) ? 3'd1 : r_gsz;
    assign valid_c = (in_d.valid_count > 3'(DP_WIDTH)) ? 3'(DP_WIDTH) : in_d.valid_count;

    assign rd_idx  = (r_state == S_GSC0 || r_state == S_GSCL) ? r_dst : r_i;
    assign rd_kind = r_kind[rd_idx];
    assign rd_sgn  = r_tsg[rd_idx];
    assign rd_exp  = r_texp[rd_idx];
    assign rd_sig  = r_tsig[rd_idx];

    assign ea  = decode_elem(r_a[16*r_lane +: 16], r_ab_fmt);
    assign eb  = decode_elem(r_b[16*r_lane +: 16], r_ab_fmt);
    assign sca = decode_scale(r_sa[8*r_grp +: 8], r_sc_fmt);
    assign scb = decode_scale(r_sb[8*r_grp +: 8], r_sc_fmt);

    assign sh = r_mx - rd_exp;
    assign al = (rd_sig >> sh[5:0]) & keep;
    assign sum_abs = r_sum[53] ? 57'(-r_sum) : 57'(r_sum);

    assign g_next = r_gstart + SW'(sg_c);
    assign g_end  = (g_next > SW'(DP_WIDTH)) ? SW'(DP_WIDTH) : g_next;
    assign p_dst  = r_sc_en ? IW'(DP_WIDTH + 1) + IW'(r_lane) : IW'(1) + IW'(r_lane);

    always_comb begin
        if (r_fnan || (r_fpi && r_fni)) spec = K_NAN;
        else if (r_fpi) spec = K_PINF;
        else if (r_fni) spec = K_NINF;
        else spec = K_ZERO;
    end

    always_comb begin
        c_kind = K_NORM;
        c_sig  = '0;
        c_exp  = '0;
        if (r_acc_fmt) begin
            c_sgn = r_c[15];
            if (r_c[14:10] == 5'h1F) c_kind = (r_c[9:0] != 10'd0) ? K_NAN
                                              : (r_c[15] ? K_NINF : K_PINF);
            else if (r_c[14:0] == 15'd0) c_kind = K_ZERO;
            c_sig = {13'd0, r_c[14:10] != 5'd0, r_c[9:0]};
            c_exp = t_exp'(((r_c[14:10] == 5'd0) ? 1 : int'(r_c[14:10])) - 25);
        end else begin
            c_sgn = r_c[31];
            if (r_c[30:23] == 8'hFF) c_kind = (r_c[22:0] != 23'd0) ? K_NAN
                                              : (r_c[31] ? K_NINF : K_PINF);
            else if (r_c[30:0] == 31'd0) c_kind = K_ZERO;
            c_sig = {r_c[30:23] != 8'd0, r_c[22:0]};
            c_exp = t_exp'(((r_c[30:23] == 8'd0) ? 1 : int'(r_c[30:23])) - 150);
        end
    end

    always_comb begin
        rnd_in.spec = r_fspec;
        rnd_in.zero = r_fzero;
        rnd_in.sign = r_nsgn;
        rnd_in.exp  = r_e;
        rnd_in.mag  = r_m;
        rnd_in.fp16 = r_acc_fmt;
        rnd_in.rne  = !r_rsel;
    end

    bsdpa_round u_round (
        .i_rnd  (rnd_in),
        .o_bits (rnd_bits)
    );

    always_comb begin
        n_state = r_state;   n_a = r_a;         n_b = r_b;
        n_sa = r_sa;         n_sb = r_sb;       n_c = r_c;
        n_lane = r_lane;     n_grp = r_grp;     n_i = r_i;
        n_lo = r_lo;         n_hi = r_hi;       n_dst = r_dst;
        n_gstart = r_gstart; n_ret = r_ret;     n_nfinal = r_nfinal;
        n_grpmode = r_grpmode;
        n_m = r_m;           n_e = r_e;         n_nsgn = r_nsgn;
        n_mx = r_mx;         n_any = r_any;     n_fnan = r_fnan;
        n_fpi = r_fpi;       n_fni = r_fni;     n_sum = r_sum;
        n_sprod = r_sprod;   n_fspec = r_fspec; n_fzero = r_fzero;
        n_out = r_out;       n_acc = r_acc;
        n_ovalid = r_ovalid && !o_out.ready;
        wr_en = 1'b0;  clr_all = 1'b0;
        wr_idx = r_dst; wr_kind = K_ZERO; wr_sgn = 1'b0; wr_exp = r_e;
        wr_sig = r_m[56:8] & keep;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    clr_all = 1'b1;
                    for (int k = 0; k < DP_WIDTH; k++) begin
                        n_a[16*k +: 16] = (3'(k) < valid_c) ? in_d.a_elems[16*k +: 16] : 16'd0;
                        n_b[16*k +: 16] = (3'(k) < valid_c) ? in_d.b_elems[16*k +: 16] : 16'd0;
                        n_sa[8*k +: 8] = (5'(k) * 5'(sg_c) < 5'(valid_c))
                                         ? in_d.scale_a[8*k +: 8] : 8'd0;
                        n_sb[8*k +: 8] = (5'(k) * 5'(sg_c) < 5'(valid_c))
                                         ? in_d.scale_b[8*k +: 8] : 8'd0;
                    end
                    n_c = in_d.first ? in_d.init_acc : r_acc;
                    if (r_acc_fmt) n_c[31:16] = 16'd0;
                    n_lane  = '0;
                    n_state = S_CDEC;
                end
            end
            S_CDEC: begin
                if (c_kind != K_NORM) begin
                    wr_en = 1'b1; wr_idx = '0; wr_kind = c_kind;
                    n_state = S_PROD;
                end else begin
                    n_m = 57'(c_sig); n_e = c_exp + t_exp'(56); n_nsgn = c_sgn;
                    n_dst = '0; n_nfinal = 1'b0; n_ret = S_PROD; n_state = S_NORM;
                end
            end
            S_PROD: begin
                n_lane = r_lane + LW'(1);
                if (r_lane == LW'(DP_WIDTH - 1)) begin
                    n_ret = r_sc_en ? S_GSTART : S_FSTART;
                    n_gstart = '0; n_grp = '0;
                end else begin
                    n_ret = S_PROD;
                end
                wr_idx = p_dst;
                if (ea.nan || eb.nan || (ea.zero && eb.inf) || (ea.inf && eb.zero)) begin
                    wr_en = 1'b1; wr_kind = K_NAN; n_state = n_ret;
                end else if (ea.zero || eb.zero) begin
                    wr_en = 1'b1; wr_kind = K_ZERO; n_state = n_ret;
                end else if (ea.inf || eb.inf) begin
                    wr_en = 1'b1; n_state = n_ret;
                    wr_kind = (ea.sign ^ eb.sign) ? K_NINF : K_PINF;
                end else begin
                    n_m = 57'(ea.sig * eb.sig);
                    n_e = ea.exp + eb.exp + t_exp'(56);
                    n_nsgn = ea.sign ^ eb.sign;
                    n_dst = p_dst; n_nfinal = 1'b0; n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_m[56]) begin
                    if (r_nfinal) begin
                        n_state = S_RND;
                    end else begin
                        wr_en = 1'b1; wr_kind = K_NORM; wr_sgn = r_nsgn;
                        n_state = r_ret;
                    end
                end else if (r_m[56:41] == 16'd0) begin
                    n_m = r_m << 16; n_e = r_e - t_exp'(16);
                end else if (r_m[56:53] == 4'd0) begin
                    n_m = r_m << 4; n_e = r_e - t_exp'(4);
                end else begin
                    n_m = r_m << 1; n_e = r_e - t_exp'(1);
                end
            end
            S_GSTART: begin
                n_i = IW'(DP_WIDTH + 1) + IW'(r_gstart);
                n_lo = n_i;
                n_hi = HW'(DP_WIDTH + 1) + HW'(g_end);
                n_any = 1'b0; n_fnan = 1'b0; n_fpi = 1'b0; n_fni = 1'b0;
                n_sum = '0; n_grpmode = 1'b1; n_state = S_MAX;
            end
            S_FSTART: begin
                n_i = '0; n_lo = '0; n_hi = HW'(DP_WIDTH + 1);
                n_any = 1'b0; n_fnan = 1'b0; n_fpi = 1'b0; n_fni = 1'b0;
                n_sum = '0; n_grpmode = 1'b0; n_state = S_MAX;
            end
            S_MAX: begin
                if (rd_kind == K_NAN) n_fnan = 1'b1;
                if (rd_kind == K_PINF) n_fpi = 1'b1;
                if (rd_kind == K_NINF) n_fni = 1'b1;
                if (rd_kind == K_NORM && (!r_any || rd_exp > r_mx)) begin
                    n_mx = rd_exp; n_any = 1'b1;
                end
                if (HW'(r_i) + HW'(1) == r_hi) begin
                    n_i = r_lo; n_state = S_SUM;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            S_SUM: begin
                if (rd_kind == K_NORM && sh <= t_exp'(w_c)) begin
                    n_sum = rd_sgn ? r_sum - 54'(al) : r_sum + 54'(al);
                end
                if (HW'(r_i) + HW'(1) == r_hi) n_state = S_REND;
                else n_i = r_i + IW'(1);
            end
            S_REND: begin
                n_m = sum_abs; n_e = r_mx + t_exp'(8); n_nsgn = r_sum[53];
                if (r_grpmode) begin
                    n_dst = IW'(1) + IW'(r_grp);
                    wr_idx = n_dst; n_ret = S_GSC0; n_nfinal = 1'b0;
                    if (spec != K_ZERO) begin
                        wr_en = 1'b1; wr_kind = spec; n_state = S_GSC0;
                    end else if (r_sum == '0) begin
                        wr_en = 1'b1; wr_kind = K_ZERO; n_state = S_GSC0;
                    end else begin
                        n_state = S_NORM;
                    end
                end else begin
                    n_fspec = spec; n_fzero = (r_sum == '0); n_nfinal = 1'b1;
                    n_state = (spec != K_ZERO || r_sum == '0) ? S_RND : S_NORM;
                end
            end
            S_GSC0: begin
                n_sprod = 8'(sca.sig * scb.sig);
                n_state = S_GSCL;
            end
            S_GSCL: begin
                n_state = S_GNEXT;
                if (rd_kind == K_NAN) begin
                    n_state = S_GNEXT;
                end else if (sca.nan || scb.nan) begin
                    wr_en = 1'b1; wr_kind = K_NAN;
                end else if (sca.zero || scb.zero) begin
                    wr_en = 1'b1; wr_kind = K_ZERO;
                end else if (rd_kind == K_NORM) begin
                    n_m = 57'(rd_sig * r_sprod);
                    n_e = rd_exp + sca.exp + scb.exp + t_exp'(8);
                    n_nsgn = rd_sgn; n_ret = S_GNEXT; n_nfinal = 1'b0;
                    n_state = S_NORM;
                end
            end
            S_GNEXT: begin
                if (g_next < SW'(DP_WIDTH)) begin
                    n_gstart = g_next; n_grp = r_grp + LW'(1); n_state = S_GSTART;
                end else begin
                    n_state = S_FSTART;
                end
            end
            S_RND: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out = rnd_bits; n_acc = rnd_bits; n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_acc     <= '0;
            r_ab_fmt  <= FMT_FP16;
            r_acc_fmt <= 1'b0;
            r_mw      <= 6'd24;
            r_sc_en   <= 1'b0;
            r_gsz     <= 3'd1;
            r_sc_fmt  <= 1'b0;
            r_rsel    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_acc    <= n_acc;
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.cfg_index)
                    REG_AB_FORMAT:    r_ab_fmt  <= i_cfg.payload.cfg_data[2:0];
                    REG_ACC_FORMAT:   r_acc_fmt <= i_cfg.payload.cfg_data[0];
                    REG_MANT_WIDTH:   r_mw      <= i_cfg.payload.cfg_data;
                    REG_SCALE_ENABLE: r_sc_en   <= i_cfg.payload.cfg_data[0];
                    REG_GROUP_SIZE:   r_gsz     <= i_cfg.payload.cfg_data[2:0];
                    REG_SCALE_FORMAT: r_sc_fmt  <= i_cfg.payload.cfg_data[0];
                    REG_ROUND_SELECT: r_rsel    <= i_cfg.payload.cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;  r_b <= n_b;  r_sa <= n_sa;  r_sb <= n_sb;  r_c <= n_c;
        r_lane <= n_lane;  r_grp <= n_grp;  r_i <= n_i;  r_lo <= n_lo;
        r_hi <= n_hi;  r_dst <= n_dst;  r_gstart <= n_gstart;  r_ret <= n_ret;
        r_nfinal <= n_nfinal;  r_grpmode <= n_grpmode;
        r_m <= n_m;  r_e <= n_e;  r_nsgn <= n_nsgn;  r_mx <= n_mx;
        r_any <= n_any;  r_fnan <= n_fnan;  r_fpi <= n_fpi;  r_fni <= n_fni;
        r_sum <= n_sum;  r_sprod <= n_sprod;  r_fspec <= n_fspec;
        r_fzero <= n_fzero;  r_out <= n_out;
        if (clr_all) begin
            for (int k = 0; k < NE; k++) r_kind[k] <= K_ZERO;
        end else if (wr_en) begin
            r_kind[wr_idx] <= wr_kind;
            r_tsg[wr_idx]  <= wr_sgn;
            r_texp[wr_idx] <= wr_exp;
            r_tsig[wr_idx] <= wr_sig;
        end
    end
endmodule

[hdl/bsdpa_chk.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the handshakes of the dot product unit and is bound to its top level.
// ----------------------------------------------------------------------------
module bsdpa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_bits,
    input logic        i_cfg_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bits))
        else $error("result changed or dropped before its transfer");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still ready right after a transfer");

    a_result_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready && !$past(i_in_ready))
        else $error("result appeared without finishing an item");

    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");
endmodule

bind block_scaled_dot_product_accumulate bsdpa_chk u_bsdpa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bits  (o_out.payload.acc_bits),
    .i_cfg_ready (i_cfg.ready)
);
